// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MISSQUOTE = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_CTRL      = 3'd5;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // decoded control characters
    localparam logic [7:0] CC_BS = 8'h08;
    localparam logic [7:0] CC_FF = 8'h0C;
    localparam logic [7:0] CC_LF = 8'h0A;
    localparam logic [7:0] CC_CR = 8'h0D;
    localparam logic [7:0] CC_HT = 8'h09;

    // utf-16 surrogate ranges, by the top six bits of a unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // group of up to four results caused by one input byte
    typedef struct packed {
        logic [2:0]      count;
        logic [1:0]      kind;
        logic [2:0]      err;
        logic [3:0][7:0] bytes;
    } t_group;

    // hex digit decode: bit 4 is valid, bits 3:0 the value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/jsu_utf8_enc.sv =====
module jsu_utf8_enc (
    input  logic [20:0]      i_cp,
    output logic [2:0]       o_count,
    output logic [3:0][7:0]  o_bytes
);
    always_comb begin
        o_bytes = '0;
        if (i_cp[20:7] == 14'd0) begin
            o_count    = 3'd1;
            o_bytes[0] = {1'b0, i_cp[6:0]};
        end else if (i_cp[20:11] == 10'd0) begin
            o_count    = 3'd2;
            o_bytes[0] = {3'b110, i_cp[10:6]};
            o_bytes[1] = {2'b10, i_cp[5:0]};
        end else if (i_cp[20:16] == 5'd0) begin
            o_count    = 3'd3;
            o_bytes[0] = {4'b1110, i_cp[15:12]};
            o_bytes[1] = {2'b10, i_cp[11:6]};
            o_bytes[2] = {2'b10, i_cp[5:0]};
        end else begin
            o_count    = 3'd4;
            o_bytes[0] = {5'b11110, i_cp[20:18]};
            o_bytes[1] = {2'b10, i_cp[17:12]};
            o_bytes[2] = {2'b10, i_cp[11:6]};
            o_bytes[3] = {2'b10, i_cp[5:0]};
        end
    end
endmodule

// ===== rtl/jsu_scan.sv =====
module jsu_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output jsu_pkg::t_group  o_group
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        ST_NORMAL  = 3'd0,
        ST_ESC     = 3'd1,
        ST_HEX1    = 3'd2,
        ST_WANT_BS = 3'd3,
        ST_WANT_U  = 3'd4,
        ST_HEX2    = 3'd5
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_first, n_first;
    logic [15:0] r_acc, n_acc;

    logic [4:0]      hex;
    logic [15:0]     acc_new;
    logic [20:0]     enc_cp;
    logic [2:0]      enc_count;
    logic [3:0][7:0] enc_bytes;

    assign hex     = hex_digit(i_byte);
    assign acc_new = {r_acc[11:0], hex[3:0]};
    // second group forms a supplementary code point, first group stands alone
    assign enc_cp  = (r_mode == ST_HEX2) ? ({1'b0, r_first, acc_new[9:0]} + SUPP_BASE)
                                         : {5'd0, acc_new};

    jsu_utf8_enc u_enc (
        .i_cp    (enc_cp),
        .o_count (enc_count),
        .o_bytes (enc_bytes)
    );

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_acc   = r_acc;
        o_group = '0;
        o_group.kind = KIND_DATA;
        o_group.err  = ERR_NONE;
        case (r_mode)
            ST_ESC: begin
                n_mode        = ST_NORMAL;
                o_group.count = 3'd1;
                case (i_byte)
                    CH_QUOTE:  o_group.bytes[0] = CH_QUOTE;
                    CH_BSLASH: o_group.bytes[0] = CH_BSLASH;
                    CH_SLASH:  o_group.bytes[0] = CH_SLASH;
                    CH_B:      o_group.bytes[0] = CC_BS;
                    CH_F:      o_group.bytes[0] = CC_FF;
                    CH_N:      o_group.bytes[0] = CC_LF;
                    CH_R:      o_group.bytes[0] = CC_CR;
                    CH_T:      o_group.bytes[0] = CC_HT;
                    CH_U: begin
                        n_mode        = ST_HEX1;
                        n_cnt         = 2'd0;
                        n_acc         = 16'd0;
                        o_group.count = 3'd0;
                    end
                    default: begin
                        o_group.kind = KIND_ERR;
                        o_group.err  = ERR_ESCAPE;
                    end
                endcase
            end
            ST_HEX1, ST_HEX2: begin
                if (!hex[4]) begin
                    n_mode        = ST_NORMAL;
                    n_cnt         = 2'd0;
                    n_acc         = 16'd0;
                    o_group.count = 3'd1;
                    o_group.kind  = KIND_ERR;
                    o_group.err   = ERR_HEX;
                end else if (r_cnt != 2'd3) begin
                    n_cnt = r_cnt + 2'd1;
                    n_acc = acc_new;
                end else begin
                    n_cnt  = 2'd0;
                    n_acc  = 16'd0;
                    n_mode = ST_NORMAL;
                    if (r_mode == ST_HEX1 && acc_new[15:10] == SURR_HIGH_TAG) begin
                        // high surrogate, hold it for the low half
                        n_first = acc_new[9:0];
                        n_mode  = ST_WANT_BS;
                    end else if (r_mode == ST_HEX2 && acc_new[15:10] != SURR_LOW_TAG) begin
                        o_group.count = 3'd1;
                        o_group.kind  = KIND_ERR;
                        o_group.err   = ERR_SURROGATE;
                    end else begin
                        o_group.count = enc_count;
                        o_group.bytes = enc_bytes;
                    end
                end
            end
            ST_WANT_BS: begin
                if (i_byte == CH_BSLASH) begin
                    n_mode = ST_WANT_U;
                end else begin
                    n_mode        = ST_NORMAL;
                    o_group.count = 3'd1;
                    o_group.kind  = KIND_ERR;
                    o_group.err   = ERR_SURROGATE;
                end
            end
            ST_WANT_U: begin
                if (i_byte == CH_U) begin
                    n_mode = ST_HEX2;
                    n_cnt  = 2'd0;
                    n_acc  = 16'd0;
                end else begin
                    n_mode        = ST_NORMAL;
                    o_group.count = 3'd1;
                    o_group.kind  = KIND_ERR;
                    o_group.err   = ERR_SURROGATE;
                end
            end
            default: begin
                n_mode        = ST_NORMAL;
                o_group.count = 3'd1;
                if (i_byte == CH_QUOTE) begin
                    o_group.kind = KIND_END;
                end else if (i_byte == CH_BSLASH) begin
                    n_mode        = ST_ESC;
                    o_group.count = 3'd0;
                end else if (i_byte == CH_NUL) begin
                    o_group.kind = KIND_ERR;
                    o_group.err  = ERR_MISSQUOTE;
                end else if (i_byte < CH_SPACE) begin
                    o_group.kind = KIND_ERR;
                    o_group.err  = ERR_CTRL;
                end else begin
                    o_group.bytes[0] = i_byte;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ST_NORMAL;
            r_cnt   <= 2'd0;
            r_first <= 10'd0;
            r_acc   <= 16'd0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_acc   <= n_acc;
        end
    end
endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-----------------------------------------
// input   | in        | i_in_valid / o_in_ready    | i_in_byte
// result  | out       | o_out_valid / i_out_ready  | o_kind, o_out_byte, o_error_code, o_last
//
// one input byte is taken per cycle while the result group register is free; a byte
// that yields n results (n = 1..4) holds that register until all n are sent, one that yields none leaves it free
// a byte passes through the input register, then is decoded into the result group register
// the rate is set by the result group register, which drains one result per cycle while the output is ready
// reset is synchronous active low and clears the scan state and both valid flags
// a stalled output holds its result; the input register can still take one byte meanwhile if it is empty
module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_error_code,
    output logic        o_last
);
    import jsu_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result group register: results still to send and the one being shown
    t_group     r_grp;
    logic [2:0] r_rem;
    logic [1:0] r_idx;

    t_group     dec_group;
    logic       grp_free;
    logic       load;
    logic       out_fire;

    assign out_fire = o_out_valid && i_out_ready;
    // group frees up when empty or when its final result leaves this cycle
    assign grp_free = (r_rem == 3'd0) || (r_rem == 3'd1 && i_out_ready);
    assign load     = r_in_valid && grp_free;
    // input register refills when it is empty or when its byte loads into the group
    assign o_in_ready = !r_in_valid || load;

    // decode the held byte against the scan state; state advances on load
    jsu_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (load),
        .i_byte  (r_in_byte),
        .o_group (dec_group)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // byte payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_idx <= 2'd0;
        end else if (load) begin
            r_rem <= dec_group.count;
            r_idx <= 2'd0;
        end else if (out_fire) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= dec_group;
        end
    end

    // result outputs come straight off the group register
    assign o_out_valid  = (r_rem != 3'd0);
    assign o_kind       = r_grp.kind;
    assign o_out_byte   = r_grp.bytes[r_idx];
    assign o_error_code = r_grp.err;
    assign o_last       = (r_rem == 3'd1);

    // an end marker or an error is always the only, and so the final, result
    a_end_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_last)
        else $error("end or error result not marked last");

    // only data results carry a byte
    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_out_byte == 8'd0)
        else $error("non-data result carries a byte");

    // error code present exactly on error results
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == KIND_ERR) == (o_error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // a utf-8 sequence is not cut short: more results follow a non-final one
    a_seq_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_last |=> o_out_valid && o_kind == KIND_DATA)
        else $error("multi-byte sequence broken");
endmodule

// ===== tb/json_string_unescape_utf8_test.sv =====
`timescale 1ns / 100ps

module json_string_unescape_utf8_test;

    import jsu_pkg::*;

    localparam int CALM_TAIL = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 350;

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_ESC,
        SCAN_HEX1,
        SCAN_WANT_BS,
        SCAN_WANT_U,
        SCAN_HEX2
    } t_scan_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
        logic       last;
    } t_decoded;

    typedef struct {
        logic [7:0] value;
        bit         settle;   // hold this byte back until every result is in
    } t_text_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic [2:0] o_error_code;
    logic       o_last;

    json_string_unescape_utf8 DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    always #10 i_clk = ~i_clk;

    // decoder state mirror
    t_scan_mode  scan_state = SCAN_NORMAL;
    logic [1:0]  digit_cnt = 2'd0;
    logic [15:0] high_unit = 16'h0000;
    logic [15:0] unit_acc = 16'h0000;

    t_text_byte  text_q[$];
    t_decoded    decoded_q[$];
    int          predicted_count = 0;
    int          results_seen = 0;
    int          fault_count = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          text_done = 1'b0;
    bit          calm_tail = 1'b0;
    t_decoded    oldest;
    t_decoded    got;

    // ---------------------------------------------------------------
    // expected results
    // ---------------------------------------------------------------

    task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic [2:0] err, input logic is_last);
        t_decoded r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.last = is_last;
        decoded_q.insert(decoded_q.size(), r);
        predicted_count++;
    endtask

    task automatic clear_scan();
        scan_state = SCAN_NORMAL;
        digit_cnt  = 2'd0;
        high_unit  = 16'h0000;
        unit_acc   = 16'h0000;
    endtask

    task automatic reject_string(input logic [2:0] err);
        clear_scan();
        push_result(KIND_ERR, 8'h00, err, 1'b1);
    endtask

    task automatic push_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            push_result(KIND_DATA, cp[7:0], ERR_NONE, 1'b1);
        end else if (cp <= 21'h7FF) begin
            push_result(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE, 1'b0);
            push_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
        end else if (cp <= 21'hFFFF) begin
            push_result(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE, 1'b0);
            push_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
            push_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
        end else begin
            push_result(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE, 1'b0);
            push_result(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE, 1'b0);
            push_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
            push_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
        end
    endtask

    // bit 4 flags a hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) begin
            return {1'b1, b[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            return {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            return {1'b1, 4'(b - 8'h57)};
        end
        return 5'd0;
    endfunction

    task automatic unescape_byte(input logic [7:0] b);
        logic [4:0]  nib;
        logic [15:0] unit;
        logic [7:0]  simple;
        bit          has_simple;
        case (scan_state)
            SCAN_ESC: begin
                has_simple = 1'b1;
                simple = b;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: simple = b;
                    CH_B: simple = CC_BS;
                    CH_F: simple = CC_FF;
                    CH_N: simple = CC_LF;
                    CH_R: simple = CC_CR;
                    CH_T: simple = CC_HT;
                    CH_U: begin
                        has_simple = 1'b0;
                        scan_state = SCAN_HEX1;
                        digit_cnt  = 2'd0;
                        unit_acc   = 16'h0000;
                    end
                    default: begin
                        has_simple = 1'b0;
                        reject_string(ERR_ESCAPE);
                    end
                endcase
                if (has_simple) begin
                    scan_state = SCAN_NORMAL;
                    push_result(KIND_DATA, simple, ERR_NONE, 1'b1);
                end
            end
            SCAN_HEX1, SCAN_HEX2: begin
                nib = hex_nibble_of(b);
                if (!nib[4]) begin
                    reject_string(ERR_HEX);
                end else begin
                    unit = {unit_acc[11:0], nib[3:0]};
                    unit_acc = unit;
                    if (digit_cnt != 2'd3) begin
                        digit_cnt++;
                    end else if (scan_state == SCAN_HEX1) begin
                        digit_cnt = 2'd0;
                        if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                            // high half, the low half must follow
                            high_unit  = unit;
                            unit_acc   = 16'h0000;
                            scan_state = SCAN_WANT_BS;
                        end else begin
                            clear_scan();
                            push_utf8({5'd0, unit});
                        end
                    end else if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                        reject_string(ERR_SURROGATE);
                    end else begin
                        push_utf8({1'b0, high_unit[9:0], unit[9:0]} + 21'h10000);
                        clear_scan();
                    end
                end
            end
            SCAN_WANT_BS: begin
                if (b != CH_BSLASH) begin
                    reject_string(ERR_SURROGATE);
                end else begin
                    scan_state = SCAN_WANT_U;
                end
            end
            SCAN_WANT_U: begin
                if (b != CH_U) begin
                    reject_string(ERR_SURROGATE);
                end else begin
                    scan_state = SCAN_HEX2;
                    digit_cnt  = 2'd0;
                    unit_acc   = 16'h0000;
                end
            end
            default: begin
                if (b == CH_QUOTE) begin
                    clear_scan();
                    push_result(KIND_END, 8'h00, ERR_NONE, 1'b1);
                end else if (b == CH_BSLASH) begin
                    scan_state = SCAN_ESC;
                end else if (b == CH_NUL) begin
                    reject_string(ERR_MISSQUOTE);
                end else if (b < CH_SPACE) begin
                    reject_string(ERR_CTRL);
                end else begin
                    push_result(KIND_DATA, b, ERR_NONE, 1'b1);
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input bit settle = 1'b0);
        t_text_byte t;
        t.value  = b;
        t.settle = settle;
        text_q.insert(text_q.size(), t);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    // four hex digits, letters in random case
    task automatic add_hex_unit(input logic [15:0] u);
        logic [3:0] n;
        for (int i = 3; i >= 0; i--) begin
            n = u[i*4 +: 4];
            if (n < 4'd10) begin
                add_byte(8'h30 + n);
            end else begin
                add_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10);
            end
        end
    endtask

    task automatic add_unit_escape(input logic [15:0] u);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_hex_unit(u);
    endtask

    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 16'h7F));
            1: return 16'($urandom_range(16'h80, 16'h7FF));
            2: return 16'($urandom_range(16'h800, 16'hFFFF));
            3: return 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_escape_char();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    task automatic add_random_token();
        int          sel;
        logic [15:0] u;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        // an occasional full drain before the token
        if ($urandom_range(0, 39) == 0) begin
            add_byte(CH_SPACE + 8'($urandom_range(1, 90)), 1'b1);
        end
        if (sel < 40) begin
            b = 8'($urandom_range(8'h20, 8'hFF));
            add_byte((b == CH_QUOTE || b == CH_BSLASH) ? 8'h61 : b);
        end else if (sel < 52) begin
            add_byte(CH_BSLASH);
            add_byte(pick_escape_char());
        end else if (sel < 66) begin
            u = pick_unit();
            add_unit_escape(u);
        end else if (sel < 76) begin
            // well-formed surrogate pair, ends of both ranges included
            add_unit_escape($urandom_range(0, 3) == 0 ? 16'hD800 :
                            16'($urandom_range(16'hD800, 16'hDBFF)));
            add_unit_escape($urandom_range(0, 3) == 0 ? 16'hDFFF :
                            16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (sel < 84) begin
            add_byte(CH_QUOTE);
        end else begin
            // noise and broken sequences
            case ($urandom_range(0, 5))
                0: add_byte(8'($urandom_range(0, 255)));
                1: begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                2: begin
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    for (int i = $urandom_range(0, 3); i > 0; i--) begin
                        add_byte(8'h30 + 8'($urandom_range(0, 9)));
                    end
                    add_byte(8'($urandom_range(0, 255)));
                end
                3: begin
                    add_unit_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                    if ($urandom_range(0, 1)) begin
                        add_byte(CH_BSLASH);
                    end
                    add_byte(8'($urandom_range(0, 255)));
                end
                4: begin
                    add_unit_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                    add_unit_escape(16'($urandom_range(0, 16'hFFFF)));
                end
                default: add_byte(8'($urandom_range(0, 8'h1F)));
            endcase
        end
    endtask

    task automatic build_stimulus();
        // plain bytes at the edges, close, end of text, control byte
        add_byte(CH_SPACE);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(CH_QUOTE);
        add_byte(CH_NUL);
        add_byte(8'h1F);
        // simple and unknown escapes, zero right after a backslash
        add_text("\\t\\q\\");
        add_byte(CH_NUL);
        // escaped zero, largest pair, lone low half
        add_text("\\u0000\\uDBFF\\uDFFF\\udfff");
        // high half followed by zero, then by a backslash and no u
        add_text("\\uD800");
        add_byte(CH_NUL, 1'b1);
        add_text("\\ud83d\\x");
        // zero and a non-hex letter inside a hex group
        add_text("\\u1");
        add_byte(CH_NUL);
        add_text("\\u12G");
        while (text_q.size() < RANDOM_BYTES) begin
            add_random_token();
        end
        add_byte(CH_QUOTE);
    endtask

    // ---------------------------------------------------------------
    // input driver
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                unescape_byte(i_in_byte);
            end
            calm_tail <= (text_q.size() <= CALM_TAIL);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (text_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                    text_done <= 1'b1;
                end else if (text_q[0].settle && predicted_count != results_seen) begin
                    i_in_valid <= 1'b0;
                end else if (text_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 7) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_byte <= text_q[0].value;
                    void'(text_q.pop_front());
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                got = {o_kind, o_out_byte, o_error_code, o_last};
                if (decoded_q.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected result, kind %0d byte %h err %0d last %b",
                             $time, got.kind, got.data, got.err, got.last);
                end else begin
                    oldest = decoded_q.pop_front();
                    if (got !== oldest) begin
                        fault_count++;
                        $display("%0t: mismatch, expected %0d/%h/%0d/%b, actual %0d/%h/%0d/%b",
                                 $time, oldest.kind, oldest.data, oldest.err, oldest.last,
                                 got.kind, got.data, got.err, got.last);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencing and end of run
    // ---------------------------------------------------------------

    initial begin
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (text_done);
        while (predicted_count != results_seen) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fault_count == 0 && decoded_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
